[src/keyword_substitution_cipher_assert.svh]
// assertion macros used by the cipher rtl
`ifndef KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH

// plain property, sampled on clk_i, off during reset
`define KSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define KSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/ksc_pkg.sv]
// shared types and constants of the keyword substitution cipher
package ksc_pkg;

  localparam int unsigned ALPHA   = 26;
  localparam int unsigned IDX_W   = $clog2(ALPHA);
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0]       LETTER_A = 8'd97;
  localparam logic [7:0]       LETTER_Z = 8'd122;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(25);

  // request codes on the input side
  localparam logic [1:0] REQ_KEY   = 2'd0;
  localparam logic [1:0] REQ_TEXT  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_TEXT,
    KIND_CLEAR
  } kind_e;

  typedef enum logic {
    BK_RUN,
    BK_FILL
  } back_state_e;

  // classified item handed from front to back
  typedef struct packed {
    kind_e            kind;
    logic             letter;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } ksc_item_t;

endpackage

[src/keyword_substitution_cipher.sv]
// top level of the keyword substitution cipher
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tuser req_type, tdata data_byte
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata out_byte
//  cfg       in   cfg_valid_i/cfg_ready_o          direction (0 decrypt, 1 encrypt)
//
// the back end sequencer takes key, clear and text bytes one at a time; a text byte waits for a free output slot
// the first text byte after reset or a clear also waits while the sequencer
// enters the walk and then walks z down to a
// a two-entry queue parts input from the sequencer, an output register
// parts the sequencer from the result side
// reset clears the letter set and fill state; tables are not cleared
module keyword_substitution_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser_i,   // [1:0] req_type
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);
  import ksc_pkg::*;

  ksc_item_t push_item, head_item;
  logic      q_full, q_push, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  // classify incoming transfers
  ksc_front u_front (
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i),
    .data_byte_i (s_axis_tdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  // decoupling queue
  ksc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (head_item)
  );

  // alphabet build and lookup
  ksc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (q_pop),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o)
  );

endmodule

[src/ksc_front.sv]
// front end: accepts requests and classifies them for the back end
module ksc_front (
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          data_byte_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output ksc_pkg::ksc_item_t  q_item_o
);
  import ksc_pkg::*;

  logic is_lower;
  logic known;
  logic [7:0] offs;
  kind_e kind;

  assign s_tready_o = !q_full_i;

  // lowercase test and letter index
  assign is_lower = (data_byte_i >= LETTER_A) && (data_byte_i <= LETTER_Z);
  assign offs     = data_byte_i - LETTER_A;

  // map the request code onto an item kind, unknown codes are dropped
  always_comb begin
    known = 1'b1;
    kind  = KIND_KEY;
    case (req_type_i)
      REQ_KEY:   kind = KIND_KEY;
      REQ_TEXT:  kind = KIND_TEXT;
      REQ_CLEAR: kind = KIND_CLEAR;
      default:   known = 1'b0;
    endcase
  end

  assign q_item_o.kind   = kind;
  assign q_item_o.letter = is_lower;
  assign q_item_o.idx    = offs[IDX_W-1:0];
  assign q_item_o.data   = data_byte_i;
  assign q_push_o        = s_tvalid_i && !q_full_i && known;

endmodule

[src/ksc_queue.sv]
// short fifo between front and back end
module ksc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ksc_pkg::ksc_item_t  item_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output ksc_pkg::ksc_item_t  item_o
);
  import ksc_pkg::*;

  ksc_item_t            mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill level update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[src/ksc_back.sv]
// back end: builds the cipher alphabet and maps text bytes
module ksc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_data_i,
  input  logic                q_valid_i,
  input  ksc_pkg::ksc_item_t  q_item_i,
  output logic                q_pop_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [7:0]          out_byte_o
);
  import ksc_pkg::*;

  `include "keyword_substitution_cipher_assert.svh"

  back_state_e            state_q, state_d;
  logic [ALPHA-1:0]       used_q, used_d;
  logic [IDX_W:0]         fill_q, fill_d;
  logic                   complete_q, complete_d;
  logic [IDX_W-1:0]       walk_q, walk_d;
  logic                   dir_q;
  logic [IDX_W-1:0]       cipher_q [ALPHA];
  logic [IDX_W-1:0]       inverse_q [ALPHA];
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_q, out_d;

  logic                   app_req;
  logic [IDX_W-1:0]       app_idx;
  logic                   app_we;
  logic                   slot_free;
  logic [IDX_W-1:0]       look;

  assign slot_free  = !out_valid_q || m_tready_i;
  assign m_tvalid_o = out_valid_q;
  assign out_byte_o = out_q;

  // an append only lands for a fresh letter while positions remain
  assign app_we = app_req && !used_q[app_idx] && (fill_q < (IDX_W + 1)'(ALPHA));

  // table lookup of the head letter
  assign look = dir_q ? cipher_q[q_item_i.idx] : inverse_q[q_item_i.idx];

  // sequencer: run items, or walk z..a to finish the alphabet
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    fill_d      = fill_q;
    complete_d  = complete_q;
    walk_d      = walk_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_d       = out_q;
    app_req     = 1'b0;
    app_idx     = q_item_i.idx;
    q_pop_o     = 1'b0;
    case (state_q)
      BK_RUN: begin
        if (q_valid_i) begin
          case (q_item_i.kind)
            KIND_KEY: begin
              q_pop_o = 1'b1;
              app_req = !complete_q && q_item_i.letter;
            end
            KIND_CLEAR: begin
              q_pop_o    = 1'b1;
              used_d     = '0;
              fill_d     = '0;
              complete_d = 1'b0;
            end
            KIND_TEXT: begin
              if (!complete_q) begin
                state_d = BK_FILL;
                walk_d  = LAST_POS;
              end else if (slot_free) begin
                q_pop_o     = 1'b1;
                out_valid_d = 1'b1;
                out_d       = q_item_i.letter ? LETTER_A + {{(8 - IDX_W){1'b0}}, look}
                                              : q_item_i.data;
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      BK_FILL: begin
        app_req = 1'b1;
        app_idx = walk_q;
        if (walk_q == '0) begin
          complete_d = 1'b1;
          state_d    = BK_RUN;
        end else begin
          walk_d = walk_q - 1'b1;
        end
      end
      default: state_d = BK_RUN;
    endcase
    if (app_we) begin
      used_d[app_idx] = 1'b1;
      fill_d          = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      used_q      <= '0;
      fill_q      <= '0;
      complete_q  <= 1'b0;
      walk_q      <= '0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      fill_q      <= fill_d;
      complete_q  <= complete_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        dir_q <= cfg_data_i;
      end
    end
  end

  // tables and output data, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (app_we) begin
      cipher_q[fill_q[IDX_W-1:0]] <= app_idx;
      inverse_q[app_idx]          <= fill_q[IDX_W-1:0];
    end
  end

  `KSC_ASSERT(a_fill_matches_used, $countones(used_q) == 32'(fill_q), "fill count off")
  `KSC_ASSERT_IMP(a_complete_full, complete_q, &used_q, "alphabet incomplete")
  `KSC_ASSERT_IMP(a_fill_not_done, state_q == BK_FILL, !complete_q && !q_pop_o,
                  "item taken during walk")
  `KSC_ASSERT_IMP(a_text_needs_table, q_pop_o && q_item_i.kind == KIND_TEXT,
                  complete_q && slot_free, "text mapped before table ready")

endmodule
